// File: hdl/cisa_pkg.sv
package cisa_pkg;

	// Register indexes of the configuration port.
	localparam logic [1:0] RegForceGain   = 2'd0;
	localparam logic [1:0] RegDistanceCap = 2'd1;

	// Reset values of the configuration registers.
	localparam logic [31:0] ForceGainReset   = 32'd589824000;
	localparam logic [30:0] DistanceCapReset = 31'd294912;

	// Iterative section: one quotient bit of the gain division per stage.
	localparam int NumIter    = 64;
	// Root bits come out of the first stages, then the direction division starts.
	localparam int SqrtSteps  = 31;
	localparam int UDivStart  = 31;
	localparam int UDivSteps  = 31;

	// State carried through one stage of the iterative section.
	typedef struct packed {
		logic              v;
		logic              skip;
		logic              push;
		logic [2:0]        neg;
		logic [2:0][30:0]  mag;
		logic [61:0]       s;
		logic [33:0]       sq_rem;
		logic [30:0]       root;
		logic [62:0]       m_rem;
		logic [63:0]       m_q;
		logic [2:0][31:0]  u_rem;
		logic [2:0][30:0]  u_q;
	} iter_t;

endpackage

// File: hdl/capped_inverse_square_attraction_unit.sv
// Stages: difference, square, sum, the 64 stages of the bit-per-stage gain division
// (also root and direction division), one product stage and the output stage.
// Throughput: one pair per cycle; the whole pipeline halts while a result waits.
// Reset: arst_n clears all valid bits and loads the default gain and cap.
module capped_inverse_square_attraction_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] attractor_x,
	input  logic [31:0] attractor_y,
	input  logic [31:0] attractor_z,
	input  logic        attractor_asleep,
	input  logic [31:0] body_x,
	input  logic [31:0] body_y,
	input  logic [31:0] body_z,
	input  logic        body_asleep,
	input  logic        same_body,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] force_x,
	output logic [31:0] force_y,
	output logic [31:0] force_z,
	output logic        applied
);

	logic        en;
	logic [31:0] force_gain_q;
	logic [30:0] distance_cap_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			force_gain_q   <= cisa_pkg::ForceGainReset;
			distance_cap_q <= cisa_pkg::DistanceCapReset;
		end else if (cfg_we) begin
			if (cfg_index == cisa_pkg::RegForceGain) begin
				force_gain_q <= cfg_wdata;
			end else if (cfg_index == cisa_pkg::RegDistanceCap) begin
				distance_cap_q <= cfg_wdata[30:0];
			end
		end
	end

	// The pipeline advances whenever the output register is free or drained.
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	// Stage 1: difference vector, magnitudes and early skip.
	logic [2:0][31:0] a_vec, b_vec;
	logic [2:0][32:0] d_c, mag_c;
	logic             skip1_c;
	logic             v_s1, skip_s1, push_s1;
	logic [2:0]       neg_s1;
	logic [2:0][32:0] mag_s1;

	assign a_vec = {attractor_z, attractor_y, attractor_x};
	assign b_vec = {body_z, body_y, body_x};

	always_comb begin
		skip1_c = body_asleep || same_body;
		for (int i = 0; i < 3; i++) begin
			d_c[i]   = {a_vec[i][31], a_vec[i]} - {b_vec[i][31], b_vec[i]};
			mag_c[i] = d_c[i][32] ? (33'd0 - d_c[i]) : d_c[i];
			if (mag_c[i] >= {2'b00, distance_cap_q}) begin
				skip1_c = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			skip_s1 <= skip1_c;
			push_s1 <= attractor_asleep;
			for (int i = 0; i < 3; i++) begin
				neg_s1[i] <= d_c[i][32];
			end
			mag_s1 <= mag_c;
		end
	end

	// Stage 2: squares of the components and of the cap.
	logic             v_s2, skip_s2, push_s2;
	logic [2:0]       neg_s2;
	logic [2:0][30:0] mag_s2;
	logic [2:0][61:0] sq_s2;
	logic [61:0]      cap2_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			skip_s2 <= skip_s1;
			push_s2 <= push_s1;
			neg_s2  <= neg_s1;
			for (int i = 0; i < 3; i++) begin
				mag_s2[i] <= mag_s1[i][30:0];
				sq_s2[i]  <= mag_s1[i][30:0] * mag_s1[i][30:0];
			end
			cap2_s2 <= distance_cap_q * distance_cap_q;
		end
	end

	// Stage 3: squared length, the zero-length test and the exact cap test.
	logic [63:0]      sum_c;
	logic             v_s3, skip_s3, push_s3;
	logic [2:0]       neg_s3;
	logic [2:0][30:0] mag_s3;
	logic [61:0]      s_s3;

	assign sum_c = {2'b00, sq_s2[0]} + {2'b00, sq_s2[1]} + {2'b00, sq_s2[2]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			skip_s3 <= skip_s2 || (sum_c == 64'd0) || (sum_c >= {2'b00, cap2_s2});
			push_s3 <= push_s2;
			neg_s3  <= neg_s2;
			mag_s3  <= mag_s2;
			s_s3    <= sum_c[61:0];
		end
	end

	// Iterative section: square root, gain division and direction division.
	cisa_pkg::iter_t init_c;
	cisa_pkg::iter_t iter_s [cisa_pkg::NumIter];

	always_comb begin
		init_c        = '0;
		init_c.v      = v_s3;
		init_c.skip   = skip_s3;
		init_c.push   = push_s3;
		init_c.neg    = neg_s3;
		init_c.mag    = mag_s3;
		init_c.s      = s_s3;
	end

	for (genvar c = 0; c < cisa_pkg::NumIter; c++) begin : g_iter
		cisa_pkg::iter_t prev_c, next_c;

		if (c == 0) begin : g_first
			assign prev_c = init_c;
		end else begin : g_next
			assign prev_c = iter_s[c-1];
		end

		always_comb begin
			logic [33:0] sq_r2, sq_trial;
			logic [62:0] m_r2;
			logic        m_nb;
			logic [31:0] u_base, u_r2;
			logic        u_nb;
			next_c   = prev_c;
			sq_r2    = '0;
			sq_trial = '0;
			u_base   = '0;
			u_r2     = '0;
			u_nb     = 1'b0;

			// One root bit from two bits of the squared length.
			if (c < cisa_pkg::SqrtSteps) begin
				sq_r2    = {prev_c.sq_rem[31:0],
					prev_c.s[(c < cisa_pkg::SqrtSteps) ?
						(2*(cisa_pkg::SqrtSteps-1-c)+1) : 1 -: 2]};
				sq_trial = {1'b0, prev_c.root, 2'b01};
				if (sq_r2 >= sq_trial) begin
					next_c.sq_rem = sq_r2 - sq_trial;
					next_c.root   = {prev_c.root[29:0], 1'b1};
				end else begin
					next_c.sq_rem = sq_r2;
					next_c.root   = {prev_c.root[29:0], 1'b0};
				end
			end

			// One quotient bit of gain * 2^32 / S.
			m_nb = (c < 32) ? force_gain_q[(c < 32) ? (31 - c) : 0] : 1'b0;
			m_r2 = {prev_c.m_rem[61:0], m_nb};
			if (m_r2 >= {1'b0, prev_c.s}) begin
				next_c.m_rem = m_r2 - {1'b0, prev_c.s};
				next_c.m_q   = {prev_c.m_q[62:0], 1'b1};
			end else begin
				next_c.m_rem = m_r2;
				next_c.m_q   = {prev_c.m_q[62:0], 1'b0};
			end

			// One quotient bit of each |D| * 2^30 / R, once the root is final.
			if (c >= cisa_pkg::UDivStart && c < cisa_pkg::UDivStart + cisa_pkg::UDivSteps) begin
				for (int i = 0; i < 3; i++) begin
					if (c == cisa_pkg::UDivStart) begin
						u_base = {2'b00, prev_c.mag[i][30:1]};
						u_nb   = prev_c.mag[i][0];
					end else begin
						u_base = prev_c.u_rem[i];
						u_nb   = 1'b0;
					end
					u_r2 = {u_base[30:0], u_nb};
					if (u_r2 >= {1'b0, prev_c.root}) begin
						next_c.u_rem[i] = u_r2 - {1'b0, prev_c.root};
						next_c.u_q[i]   = {prev_c.u_q[i][29:0], 1'b1};
					end else begin
						next_c.u_rem[i] = u_r2;
						next_c.u_q[i]   = {prev_c.u_q[i][29:0], 1'b0};
					end
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				iter_s[c] <= '0;
			end else if (en) begin
				iter_s[c] <= next_c;
			end
		end
	end

	// Product stage: partial products of the magnitude and each unit component.
	cisa_pkg::iter_t  last_c;
	logic             v_s68, skip_s68;
	logic [2:0]       negative_s68;
	logic [2:0][62:0] lo_s68, hi_s68;

	assign last_c = iter_s[cisa_pkg::NumIter-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s68 <= 1'b0;
		end else if (en) begin
			v_s68 <= last_c.v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			skip_s68 <= last_c.skip;
			for (int i = 0; i < 3; i++) begin
				negative_s68[i] <= last_c.neg[i] ^ last_c.push;
				lo_s68[i]       <= last_c.m_q[31:0] * last_c.u_q[i];
				hi_s68[i]       <= last_c.m_q[63:32] * last_c.u_q[i];
			end
		end
	end

	// Output stage: combine, scale, saturate, apply the sign and zero skipped pairs.
	logic [2:0][31:0] frc_c;

	always_comb begin
		logic [94:0] full;
		logic [64:0] q;
		logic [31:0] lim, f;
		for (int i = 0; i < 3; i++) begin
			full = {hi_s68[i], 32'd0} + {32'd0, lo_s68[i]};
			q    = full[94:30];
			lim  = negative_s68[i] ? 32'h8000_0000 : 32'h7FFF_FFFF;
			f    = (q > {33'd0, lim}) ? lim : q[31:0];
			if (skip_s68) begin
				frc_c[i] = 32'd0;
			end else begin
				frc_c[i] = negative_s68[i] ? (32'd0 - f) : f;
			end
		end
	end

	logic [2:0][31:0] frc_s69;
	logic             applied_s69;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= v_s68;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			frc_s69     <= frc_c;
			applied_s69 <= !skip_s68;
		end
	end

	assign force_x = frc_s69[0];
	assign force_y = frc_s69[1];
	assign force_z = frc_s69[2];
	assign applied = applied_s69;

endmodule
